FILE: src/tkf_pkg.sv
// ----------------------------------------------------------------------------
// tkf_pkg
// Shared types and constants for the top-k score threshold filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tkf_pkg;

    localparam int OPCODE_W = 1;
    localparam int SCORE_W  = 11;
    localparam int LIMIT_W  = 12;
    localparam int THRESH_W = 12;
    localparam int TOTAL_W  = 20;

    localparam logic [LIMIT_W-1:0]  LIMIT_RESET = 12'd10;

    localparam logic [OPCODE_W-1:0] OP_CLEAR = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_OFFER = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INC,
        ST_CHECK,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

FILE: src/tkf_hist_ram.sv
// ----------------------------------------------------------------------------
// tkf_hist_ram
// Histogram store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tkf_hist_ram #(
    parameter int ADDR_W = 11,
    parameter int DATA_W = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: src/top_k_score_threshold_filter_core.sv
// ----------------------------------------------------------------------------
// top_k_score_threshold_filter_core
// Keeps a histogram of accepted scores and a rising minimum so that at least
// keep_limit of the best candidates survive.
// ----------------------------------------------------------------------------
// One item is taken at a time; the histogram sits in a single-port-read,
// single-port-write memory, so timing is set by that memory port. An
// offered score that leaves the minimum in place passes through the
// increment and check states; when the minimum rises, a scan walks up from
// the old minimum to the next occupied bin or the score's own bin. A
// rejected score, or any score while keep_limit is zero, goes straight to
// the finish state. A clear word is followed by a clearing pass over every
// bin during which no word is taken; the same pass runs after reset. The
// result register lets a new word enter while the previous result is still stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module top_k_score_threshold_filter_core #(
    parameter int SCORE_BITS     = 11,
    parameter int BIN_COUNT_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // input channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [tkf_pkg::OPCODE_W-1:0]        i_opcode,
    input  wire logic [tkf_pkg::SCORE_W-1:0]         i_score,
    // output channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic                                     o_accepted,
    output logic signed [tkf_pkg::THRESH_W-1:0]      o_threshold,
    output logic [tkf_pkg::TOTAL_W-1:0]              o_kept_total,
    // configuration
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [tkf_pkg::LIMIT_W-1:0]         i_cfg_keep_limit
);

    localparam int MIN_W   = SCORE_BITS + 1;
    localparam int TOT_W   = tkf_pkg::TOTAL_W;
    localparam int THR_W   = tkf_pkg::THRESH_W;
    localparam int CMP_W   = (BIN_COUNT_BITS > TOT_W) ? BIN_COUNT_BITS : TOT_W;

    tkf_pkg::t_state r_state, n_state;

    logic [tkf_pkg::LIMIT_W-1:0]  r_limit;
    logic [tkf_pkg::OPCODE_W-1:0] r_op, n_op;
    logic [SCORE_BITS-1:0]        r_s, n_s;
    logic [MIN_W-1:0]             r_min, n_min;
    logic [TOT_W-1:0]             r_total, n_total;
    logic [SCORE_BITS-1:0]        r_b, n_b;
    logic [SCORE_BITS-1:0]        r_clr_addr, n_clr_addr;
    logic                         r_accepted, n_accepted;

    logic                         r_out_valid, n_out_valid;
    logic                         r_out_accepted, n_out_accepted;
    logic [THR_W-1:0]             r_out_threshold, n_out_threshold;
    logic [TOT_W-1:0]             r_out_total, n_out_total;

    logic                         ram_we;
    logic [SCORE_BITS-1:0]        ram_waddr;
    logic [BIN_COUNT_BITS-1:0]    ram_wdata;
    logic [SCORE_BITS-1:0]        ram_raddr;
    logic [BIN_COUNT_BITS-1:0]    ram_rdata;

    logic                         in_accept;
    logic                         out_free;
    logic [SCORE_BITS-1:0]        s_in;
    logic                         min_neg;
    logic [SCORE_BITS-1:0]        min_addr;
    logic [SCORE_BITS-1:0]        min_next;
    logic                         s_above;
    logic [BIN_COUNT_BITS-1:0]    bin_inc;
    logic [TOT_W-1:0]             total_inc;
    logic [CMP_W-1:0]             mc_cmp;
    logic [CMP_W-1:0]             total_cmp;
    logic [CMP_W-1:0]             above_cmp;
    logic                         raise;
    logic                         scan_stop;
    logic [THR_W-1:0]             thr_ext;

    tkf_hist_ram #(
        .ADDR_W (SCORE_BITS),
        .DATA_W (BIN_COUNT_BITS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall  = (r_state != tkf_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign s_in     = SCORE_BITS'(i_score);
    assign min_neg  = r_min[MIN_W-1];
    assign min_addr = r_min[SCORE_BITS-1:0];
    assign min_next = min_addr + SCORE_BITS'(1);
    assign s_above  = min_neg || (s_in > min_addr);

    assign bin_inc   = (ram_rdata == '1) ? ram_rdata : ram_rdata + BIN_COUNT_BITS'(1);
    assign total_inc = (r_total == '1) ? r_total : r_total + TOT_W'(1);

    assign mc_cmp    = min_neg ? '0 : CMP_W'(ram_rdata);
    assign total_cmp = CMP_W'(r_total);
    assign above_cmp = (total_cmp > mc_cmp) ? total_cmp - mc_cmp : '0;
    assign raise     = (above_cmp >= CMP_W'(r_limit));

    assign scan_stop = (r_b == r_s) || (ram_rdata != '0);

    generate
        if (MIN_W >= THR_W) begin : g_thr_trunc
            assign thr_ext = r_min[THR_W-1:0];
        end else begin : g_thr_sext
            assign thr_ext = {{(THR_W-MIN_W){r_min[MIN_W-1]}}, r_min};
        end
    endgenerate

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tkf_pkg::ST_CLEAR: begin
                if (r_clr_addr == '1) begin
                    n_state = tkf_pkg::ST_IDLE;
                end
            end
            tkf_pkg::ST_IDLE: begin
                if (in_accept) begin
                    if (i_opcode == tkf_pkg::OP_OFFER && r_limit != '0 && s_above) begin
                        n_state = tkf_pkg::ST_INC;
                    end else begin
                        n_state = tkf_pkg::ST_FINISH;
                    end
                end
            end
            tkf_pkg::ST_INC: begin
                n_state = tkf_pkg::ST_CHECK;
            end
            tkf_pkg::ST_CHECK: begin
                n_state = raise ? tkf_pkg::ST_SCAN : tkf_pkg::ST_FINISH;
            end
            tkf_pkg::ST_SCAN: begin
                if (scan_stop) begin
                    n_state = tkf_pkg::ST_FINISH;
                end
            end
            tkf_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_state = (r_op == tkf_pkg::OP_CLEAR) ? tkf_pkg::ST_CLEAR
                                                          : tkf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tkf_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb begin
        ram_we          = 1'b0;
        ram_waddr       = r_s;
        ram_wdata       = '0;
        ram_raddr       = s_in;
        n_op            = r_op;
        n_s             = r_s;
        n_min           = r_min;
        n_total         = r_total;
        n_b             = r_b;
        n_clr_addr      = r_clr_addr;
        n_accepted      = r_accepted;
        n_out_valid     = r_out_valid && i_out_stall;
        n_out_accepted  = r_out_accepted;
        n_out_threshold = r_out_threshold;
        n_out_total     = r_out_total;
        case (r_state)
            tkf_pkg::ST_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + SCORE_BITS'(1);
            end
            tkf_pkg::ST_IDLE: begin
                ram_raddr = s_in;
                if (in_accept) begin
                    n_op       = i_opcode;
                    n_s        = s_in;
                    n_accepted = 1'b0;
                    if (i_opcode == tkf_pkg::OP_OFFER) begin
                        if (r_limit == '0 || s_above) begin
                            n_accepted = 1'b1;
                        end
                    end else begin
                        n_total = '0;
                        n_min   = '1;
                    end
                end
            end
            tkf_pkg::ST_INC: begin
                // bump the score's bin, fetch the minimum's bin
                ram_we    = 1'b1;
                ram_waddr = r_s;
                ram_wdata = bin_inc;
                ram_raddr = min_addr;
                n_total   = total_inc;
            end
            tkf_pkg::ST_CHECK: begin
                ram_raddr = min_next;
                if (raise) begin
                    n_total   = above_cmp[TOT_W-1:0];
                    ram_we    = !min_neg;
                    ram_waddr = min_addr;
                    ram_wdata = '0;
                    n_b       = min_next;
                end
            end
            tkf_pkg::ST_SCAN: begin
                ram_raddr = r_b + SCORE_BITS'(1);
                if (scan_stop) begin
                    n_min = {1'b0, r_b};
                end else begin
                    n_b = r_b + SCORE_BITS'(1);
                end
            end
            tkf_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out_accepted  = r_accepted;
                    n_out_threshold = thr_ext;
                    n_out_total     = r_total;
                    n_clr_addr      = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tkf_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_total     <= '0;
            r_min       <= '1;
            r_out_valid <= 1'b0;
            r_limit     <= tkf_pkg::LIMIT_RESET;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_total     <= n_total;
            r_min       <= n_min;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_keep_limit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op            <= n_op;
        r_s             <= n_s;
        r_b             <= n_b;
        r_accepted      <= n_accepted;
        r_out_accepted  <= n_out_accepted;
        r_out_threshold <= n_out_threshold;
        r_out_total     <= n_out_total;
    end

    assign o_out_valid  = r_out_valid;
    assign o_accepted   = r_out_accepted;
    assign o_threshold  = r_out_threshold;
    assign o_kept_total = r_out_total;

endmodule

`default_nettype wire

FILE: src/tkf_checker.sv
// ----------------------------------------------------------------------------
// tkf_checker
// Port-level checks for the top-k score threshold filter, bound to the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tkf_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_stall,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_stall,
    input wire logic                           o_accepted,
    input wire logic [tkf_pkg::THRESH_W-1:0]   o_threshold,
    input wire logic [tkf_pkg::TOTAL_W-1:0]    o_kept_total
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_accepted) && $stable(o_threshold)
             && $stable(o_kept_total)))
        else $error("stalled result word changed");

    // one word in flight at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while previous word in progress");

    // a result word only follows work in progress
    a_out_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result word without a word in progress");

    // clearing pass after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_in_stall && !o_out_valid))
        else $error("input open right after reset");

endmodule

bind top_k_score_threshold_filter_core tkf_checker u_tkf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_accepted   (o_accepted),
    .o_threshold  (o_threshold),
    .o_kept_total (o_kept_total)
);

`default_nettype wire

FILE: test/tb_top_k_score_threshold_filter_core.sv
// ----------------------------------------------------------------------------
// tb_top_k_score_threshold_filter_core
// Streams clear and offer words through the top-k score threshold filter
// under several keep_limit settings, with random idling on both sides and one
// long output hold-off. A local model of the histogram, running total and
// rising minimum predicts each result word, which is checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top_k_score_threshold_filter_core;

    localparam int OP_W       = tkf_pkg::OPCODE_W;
    localparam int SC_W       = tkf_pkg::SCORE_W;
    localparam int THR_W      = tkf_pkg::THRESH_W;
    localparam int TOT_W      = tkf_pkg::TOTAL_W;
    localparam int LIM_W      = tkf_pkg::LIMIT_W;
    localparam int SCORE_BINS = 1 << SC_W;
    localparam int SCORE_MAX  = SCORE_BINS - 1;
    localparam int PHASES     = 8;

    typedef struct {
        logic [OP_W-1:0] opcode;
        logic [SC_W-1:0] score;
    } t_offer_word;

    typedef struct packed {
        logic             accepted;
        logic [THR_W-1:0] threshold;
        logic [TOT_W-1:0] kept_total;
    } t_verdict;

    logic                    i_clk            = 1'b0;
    logic                    i_rst_n          = 1'b0;
    logic                    i_in_valid       = 1'b0;
    logic                    o_in_stall;
    logic [OP_W-1:0]         i_opcode         = tkf_pkg::OP_OFFER;
    logic [SC_W-1:0]         i_score          = '0;
    logic                    o_out_valid;
    logic                    i_out_stall      = 1'b0;
    logic                    o_accepted;
    logic signed [THR_W-1:0] o_threshold;
    logic [TOT_W-1:0]        o_kept_total;
    logic                    i_cfg_valid      = 1'b0;
    logic                    o_cfg_ready;
    logic [LIM_W-1:0]        i_cfg_keep_limit = tkf_pkg::LIMIT_RESET;

    // model state
    logic [15:0]             bin_count [0:SCORE_BINS-1] = '{default: '0};
    logic [TOT_W-1:0]        kept_count     = '0;
    logic signed [THR_W-1:0] model_floor    = '1;
    logic [LIM_W-1:0]        keep_limit_now = tkf_pkg::LIMIT_RESET;

    t_offer_word word_q[$];
    t_verdict    pending_verdicts[$];

    logic in_fired       = 1'b0;
    logic idle_en        = 1'b0;
    logic holdoff_done   = 1'b0;
    int   accepted_words = 0;
    int   mismatch_count = 0;
    int   send_gap       = 0;
    int   send_rate      = 0;
    int   send_cyc       = 0;
    int   stall_left     = 0;
    int   stall_rate     = 0;
    int   stall_cyc      = 0;
    int   holdoff_left   = 0;
    int   window_base    = 0;
    logic [SC_W-1:0] last_score = '0;

    int unsigned limit_plan [PHASES] = '{10, 0, 1, 4095, 2048, 3, 37, 10};
    int          word_plan  [PHASES] = '{300, 100, 200, 150, 100, 250, 200, 150};

    top_k_score_threshold_filter_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_score          (i_score),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_accepted       (o_accepted),
        .o_threshold      (o_threshold),
        .o_kept_total     (o_kept_total),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_keep_limit (i_cfg_keep_limit)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_verdict threshold_filter_step(input logic [OP_W-1:0] op,
                                                       input logic [SC_W-1:0] sc);
        t_verdict r;
        int       mc;
        int       above;
        int       b;
        r.accepted = 1'b0;
        if (op == tkf_pkg::OP_CLEAR) begin
            foreach (bin_count[i]) bin_count[i] = '0;
            kept_count  = '0;
            model_floor = '1;
        end else if (keep_limit_now == '0) begin
            r.accepted = 1'b1;
        end else if (int'(sc) > int'(model_floor)) begin
            r.accepted = 1'b1;
            if (kept_count != '1) kept_count = kept_count + 1'b1;
            if (bin_count[sc] != '1) bin_count[sc] = bin_count[sc] + 1'b1;
            mc    = (model_floor < 0) ? 0 : int'(bin_count[model_floor[SC_W-1:0]]);
            above = (int'(kept_count) > mc) ? int'(kept_count) - mc : 0;
            if (above >= int'(keep_limit_now)) begin
                kept_count = TOT_W'(above);
                if (model_floor >= 0) bin_count[model_floor[SC_W-1:0]] = '0;
                // walk up to the next occupied bin
                b = int'(model_floor) + 1;
                while (b < int'(sc) && bin_count[SC_W'(b)] == '0) b++;
                model_floor = THR_W'(b);
            end
        end
        r.threshold  = model_floor;
        r.kept_total = kept_count;
        return r;
    endfunction

    always @(posedge i_clk) begin : result_monitor
        t_verdict want;
        t_verdict next_v;
        in_fired = i_rst_n && i_in_valid && !o_in_stall;
        if (in_fired) begin
            next_v = threshold_filter_step(i_opcode, i_score);
            pending_verdicts.insert(pending_verdicts.size(), next_v);
            accepted_words++;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected result word, accepted %0d threshold %0d total %0d",
                         $time, o_accepted, o_threshold, o_kept_total);
                mismatch_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (o_accepted !== want.accepted) begin
                    $display("%0t: accepted mismatch, expected %0d, got %0d",
                             $time, want.accepted, o_accepted);
                    mismatch_count++;
                end
                if (o_threshold !== want.threshold) begin
                    $display("%0t: threshold mismatch, expected %0d, got %0d",
                             $time, $signed(want.threshold), o_threshold);
                    mismatch_count++;
                end
                if (o_kept_total !== want.kept_total) begin
                    $display("%0t: kept_total mismatch, expected %0d, got %0d",
                             $time, want.kept_total, o_kept_total);
                    mismatch_count++;
                end
            end
        end
    end

    always @(negedge i_clk) begin : word_driver
        t_offer_word w;
        logic        holding;
        holding = i_in_valid && !in_fired;
        if (!i_rst_n) begin
            holding = 1'b0;
        end else if (!holding) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (word_q.size() > 0) begin
                if (idle_en && send_rate > 0 && $urandom_range(0, 15) < send_rate) begin
                    send_gap = $urandom_range(0, 16);
                end else begin
                    w       = word_q.pop_front();
                    holding = 1'b1;
                    i_opcode <= w.opcode;
                    i_score  <= w.score;
                end
            end
        end
        i_in_valid <= holding;
        send_cyc++;
        if (send_cyc % 128 == 0) send_rate = $urandom_range(0, 3);
    end

    always @(negedge i_clk) begin : result_stall
        logic nxt;
        nxt = 1'b0;
        if (i_rst_n) begin
            // one long hold-off so the core backs up into its input
            if (!holdoff_done && accepted_words >= 150) begin
                holdoff_left = 400;
                holdoff_done = 1'b1;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                nxt = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                nxt = 1'b1;
            end else if (idle_en && stall_rate > 0 && $urandom_range(0, 15) < stall_rate) begin
                stall_left = $urandom_range(0, 16);
                nxt        = 1'b1;
            end
        end
        i_out_stall <= nxt;
        stall_cyc++;
        if (stall_cyc % 96 == 0) stall_rate = $urandom_range(0, 3);
    end

    task automatic push_word(input logic [OP_W-1:0] op, input int sc);
        t_offer_word w;
        w.opcode = op;
        w.score  = SC_W'(sc);
        word_q.insert(word_q.size(), w);
    endtask

    task automatic queue_random_words(input int n);
        t_offer_word w;
        int          pick;
        for (int k = 0; k < n; k++) begin
            pick     = $urandom_range(0, 99);
            w.opcode = tkf_pkg::OP_OFFER;
            if (pick < 2) begin
                w.opcode    = tkf_pkg::OP_CLEAR;
                w.score     = SC_W'($urandom);
                window_base = $urandom_range(0, 255);
            end else if (pick < 62) begin
                // drifting window keeps scores near the rising minimum
                w.score     = SC_W'(window_base + $urandom_range(0, 31));
                window_base = window_base + $urandom_range(0, 3);
                if (window_base > SCORE_MAX - 31) window_base = SCORE_MAX - 31;
            end else if (pick < 82) begin
                w.score = SC_W'($urandom);
            end else if (pick < 90) begin
                w.score = last_score;
            end else begin
                w.score = SC_W'($urandom_range(0, 1) ? SCORE_MAX : $urandom_range(0, 1));
            end
            last_score = w.score;
            word_q.insert(word_q.size(), w);
        end
    endtask

    task automatic wait_for_drain();
        while (word_q.size() != 0 || i_in_valid || pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_keep_limit(input logic [LIM_W-1:0] v);
        @(negedge i_clk);
        i_cfg_valid      <= 1'b1;
        i_cfg_keep_limit <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        keep_limit_now = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : test_sequence
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        idle_en = 1'b1;

        // extremes, repeated bins, a long scan and rejections at the minimum
        push_word(tkf_pkg::OP_OFFER, 0);
        push_word(tkf_pkg::OP_OFFER, SCORE_MAX);
        push_word(tkf_pkg::OP_OFFER, 0);
        push_word(tkf_pkg::OP_OFFER, 0);
        push_word(tkf_pkg::OP_OFFER, 1024);
        push_word(tkf_pkg::OP_OFFER, 1024);
        push_word(tkf_pkg::OP_OFFER, 5);
        push_word(tkf_pkg::OP_OFFER, 7);
        push_word(tkf_pkg::OP_OFFER, 1023);
        push_word(tkf_pkg::OP_OFFER, SCORE_MAX - 1);
        push_word(tkf_pkg::OP_OFFER, 0);
        push_word(tkf_pkg::OP_OFFER, 3);
        push_word(tkf_pkg::OP_OFFER, SCORE_MAX);
        push_word(tkf_pkg::OP_OFFER, SCORE_MAX);
        push_word(tkf_pkg::OP_OFFER, 1);
        push_word(tkf_pkg::OP_OFFER, 3);
        push_word(tkf_pkg::OP_CLEAR, SCORE_MAX);
        push_word(tkf_pkg::OP_OFFER, SCORE_MAX);
        push_word(tkf_pkg::OP_OFFER, 0);
        push_word(tkf_pkg::OP_CLEAR, 0);
        push_word(tkf_pkg::OP_OFFER, 1);

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) write_keep_limit(LIM_W'(limit_plan[p]));
            if (p == PHASES - 1) idle_en = 1'b0;
            window_base = $urandom_range(0, 255);
            queue_random_words(word_plan[p]);
            wait_for_drain();
        end

        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : watchdog
        #30_000_000;
        $display("%0t: timeout", $time);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
